// ===== rtl/core/nsls_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package nsls_pkg;

	localparam int LENGTH_BITS_DEF = 24;
	localparam int RADIX_COUNT_DEF = 6;
	localparam int RADIX_W         = 8;
	localparam int NUM_CFG         = 6;
	localparam int CFG_IDX_W       = 3;

	localparam logic [RADIX_W-1:0] RADIX_RESET [NUM_CFG] = '{
		8'd7, 8'd6, 8'd5, 8'd4, 8'd3, 8'd2
	};

	// datapath commands from the controller
	typedef struct packed {
		logic load;       // take a new request as first candidate
		logic cand_inc;   // step to next candidate
		logic quot_init;  // quotient <= candidate, list position <= 0
		logic div_start;  // divide quotient by current radix
		logic quot_take;  // quotient <= divider quotient
		logic idx_inc;    // move on to next radix
		logic out_found;  // load result with accepted candidate
		logic out_ovf;    // load overflow result
	} cmd_t;

	// datapath status to the controller
	typedef struct packed {
		logic list_empty;
		logic cand_over;
		logic cand_lt2;
		logic radix_ok;
		logic quot_one;
		logic div_done;
		logic rem_zero;
	} status_t;

endpackage

`default_nettype wire

// ===== rtl/core/nsls_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module nsls_div #(
	parameter int LENGTH_BITS = nsls_pkg::LENGTH_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [LENGTH_BITS-1:0]       dividend,
	input  wire logic [nsls_pkg::RADIX_W-1:0] divisor,
	output logic                              done,
	output logic [LENGTH_BITS-1:0]            quotient,
	output logic [nsls_pkg::RADIX_W-1:0]      remainder
);

	localparam int RW    = nsls_pkg::RADIX_W;
	localparam int CNT_W = $clog2(LENGTH_BITS + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [LENGTH_BITS-1:0] quo_q;
	logic [RW-1:0]    rem_q;
	logic [RW-1:0]    div_q;

	logic [RW:0] trial;
	logic [RW:0] diff;
	logic        ge;

	// restoring division, one quotient bit per cycle
	always_comb begin
		trial = {rem_q, quo_q[LENGTH_BITS-1]};
		diff  = trial - {1'b0, div_q};
		ge    = (trial >= {1'b0, div_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(LENGTH_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[LENGTH_BITS-2:0], ge};
			rem_q <= ge ? diff[RW-1:0] : trial[RW-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

// ===== rtl/core/nsls_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module nsls_dpath #(
	parameter int LENGTH_BITS = nsls_pkg::LENGTH_BITS_DEF,
	parameter int RADIX_COUNT = nsls_pkg::RADIX_COUNT_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [nsls_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [nsls_pkg::RADIX_W-1:0]   cfg_data,
	input  wire logic [LENGTH_BITS-1:0]         requested_length,
	input  wire nsls_pkg::cmd_t                 cmd,
	output nsls_pkg::status_t                   status,
	output logic [LENGTH_BITS-1:0]              padded_length,
	output logic                                already_fit,
	output logic                                search_overflow
);

	localparam int RW    = nsls_pkg::RADIX_W;
	localparam int IDX_W = (RADIX_COUNT < 2) ? 1 : $clog2(RADIX_COUNT + 1);

	logic [RW-1:0]          radix_q [nsls_pkg::NUM_CFG];
	logic [LENGTH_BITS:0]   cand_q;
	logic [LENGTH_BITS-1:0] quot_q;
	logic [IDX_W-1:0]       idx_q;
	logic                   first_q;
	logic [LENGTH_BITS-1:0] padded_q;
	logic                   fit_q;
	logic                   ovf_q;

	logic [3:0]             slot;
	logic [RW-1:0]          radix_cur;
	logic                   div_done;
	logic [LENGTH_BITS-1:0] div_quot;
	logic [RW-1:0]          div_rem;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < nsls_pkg::NUM_CFG; i++) begin
				radix_q[i] <= nsls_pkg::RADIX_RESET[i];
			end
		end else if (cfg_we && (32'(cfg_index) < 32'(nsls_pkg::NUM_CFG))) begin
			radix_q[cfg_index] <= cfg_data;
		end
	end

	// list slots past the register set read as zero
	always_comb begin
		slot = 4'(idx_q);
		if (slot < 4'(nsls_pkg::NUM_CFG)) begin
			radix_cur = radix_q[slot[2:0]];
		end else begin
			radix_cur = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cand_q  <= {1'b0, requested_length};
			first_q <= 1'b1;
		end else if (cmd.cand_inc) begin
			cand_q  <= cand_q + 1'b1;
			first_q <= 1'b0;
		end
		if (cmd.quot_init) begin
			quot_q <= cand_q[LENGTH_BITS-1:0];
		end else if (cmd.quot_take) begin
			quot_q <= div_quot;
		end
		if (cmd.quot_init) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + 1'b1;
		end
		if (cmd.out_found) begin
			padded_q <= cand_q[LENGTH_BITS-1:0];
			fit_q    <= first_q;
			ovf_q    <= 1'b0;
		end else if (cmd.out_ovf) begin
			padded_q <= '0;
			fit_q    <= 1'b0;
			ovf_q    <= 1'b1;
		end
	end

	nsls_div #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (quot_q),
		.divisor   (radix_cur),
		.done      (div_done),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	always_comb begin
		status.list_empty = (radix_q[0] < RW'(2));
		status.cand_over  = cand_q[LENGTH_BITS];
		status.cand_lt2   = (cand_q < (LENGTH_BITS+1)'(2));
		status.radix_ok   = (idx_q < IDX_W'(RADIX_COUNT)) && (radix_cur >= RW'(2));
		status.quot_one   = (quot_q == LENGTH_BITS'(1));
		status.div_done   = div_done;
		status.rem_zero   = (div_rem == '0);
	end

	assign padded_length   = padded_q;
	assign already_fit     = fit_q;
	assign search_overflow = ovf_q;

endmodule

`default_nettype wire

// ===== rtl/core/nsls_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module nsls_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_stall,
	output logic                   res_valid,
	input  wire logic              res_stall,
	input  wire nsls_pkg::status_t status,
	output nsls_pkg::cmd_t         cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_CAND,
		ST_RADIX,
		ST_DIV,
		ST_DIV_AGAIN,
		ST_FIN_OK,
		ST_FIN_OVF
	} state_t;

	state_t state_q;
	logic   res_valid_q;
	logic   slot_free;

	assign slot_free = !res_valid_q || !res_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign res_valid = res_valid_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.load = req_valid;
			end
			ST_CAND: begin
				if (!status.cand_over) begin
					if (status.cand_lt2) begin
						cmd.cand_inc = 1'b1;
					end else begin
						cmd.quot_init = 1'b1;
					end
				end
			end
			ST_RADIX: begin
				if (!status.quot_one) begin
					if (status.radix_ok) begin
						cmd.div_start = 1'b1;
					end else begin
						cmd.cand_inc = 1'b1;
					end
				end
			end
			ST_DIV: begin
				if (status.div_done) begin
					if (status.rem_zero) begin
						cmd.quot_take = 1'b1;
					end else begin
						cmd.idx_inc = 1'b1;
					end
				end
			end
			ST_DIV_AGAIN: begin
				cmd.div_start = 1'b1;
			end
			ST_FIN_OK: begin
				cmd.out_found = slot_free;
			end
			ST_FIN_OVF: begin
				cmd.out_ovf = slot_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && !res_stall && !cmd.out_found && !cmd.out_ovf) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_START;
					end
				end
				ST_START: begin
					state_q <= status.list_empty ? ST_FIN_OVF : ST_CAND;
				end
				ST_CAND: begin
					if (status.cand_over) begin
						state_q <= ST_FIN_OVF;
					end else if (!status.cand_lt2) begin
						state_q <= ST_RADIX;
					end
				end
				ST_RADIX: begin
					if (status.quot_one) begin
						state_q <= ST_FIN_OK;
					end else if (status.radix_ok) begin
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_CAND;
					end
				end
				ST_DIV: begin
					if (status.div_done) begin
						// keep dividing by the same radix while it divides evenly
						state_q <= status.rem_zero ? ST_DIV_AGAIN : ST_RADIX;
					end
				end
				ST_DIV_AGAIN: begin
					state_q <= ST_DIV;
				end
				ST_FIN_OK, ST_FIN_OVF: begin
					if (slot_free) begin
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/next_smooth_length_search_core.sv =====
// the search tries candidates upward from the requested length; each candidate is divided by
// the radices in list order on the bit-serial divider, repeating a radix while it divides evenly,
// a candidate below two is skipped, and a search past the largest length ends in overflow
// one item at a time; the next item is taken while the result first sits in the output
// register, and a stalled result holds the search in its last state
// arst_n clears control state and loads the radix registers with 7, 6, 5, 4, 3, 2
`timescale 1ns / 1ps
`default_nettype none

module next_smooth_length_search_core #(
	parameter int LENGTH_BITS = nsls_pkg::LENGTH_BITS_DEF,
	parameter int RADIX_COUNT = nsls_pkg::RADIX_COUNT_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [nsls_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [nsls_pkg::RADIX_W-1:0]   cfg_data,
	input  wire logic                           req_valid,
	output logic                                req_stall,
	input  wire logic [LENGTH_BITS-1:0]         requested_length,
	output logic                                res_valid,
	input  wire logic                           res_stall,
	output logic [LENGTH_BITS-1:0]              padded_length,
	output logic                                already_fit,
	output logic                                search_overflow
);

	nsls_pkg::cmd_t    cmd;
	nsls_pkg::status_t status;

	assign cfg_ready = 1'b1;

	nsls_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.status    (status),
		.cmd       (cmd)
	);

	nsls_dpath #(
		.LENGTH_BITS(LENGTH_BITS),
		.RADIX_COUNT(RADIX_COUNT)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_valid & cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.requested_length (requested_length),
		.cmd              (cmd),
		.status           (status),
		.padded_length    (padded_length),
		.already_fit      (already_fit),
		.search_overflow  (search_overflow)
	);

endmodule

`default_nettype wire
